### rtl/three_channel_ema_load_monitor_macros.svh
// ----------------------------------------------------------------------------
// Load monitor assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified by argument.
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_EMA_LOAD_MONITOR_MACROS_SVH
`define THREE_CHANNEL_EMA_LOAD_MONITOR_MACROS_SVH

// condition must hold at every edge outside reset
`define TCLM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TCLM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/tclm_pkg.sv
// ----------------------------------------------------------------------------
// Load monitor package
// Widths, constants, the queue entry type and small helpers.
// ----------------------------------------------------------------------------
package tclm_pkg;

   localparam int DUR_BITS      = 24;              // running average width
   localparam int IN_DUR_BITS   = 24;              // duration field width
   localparam int SUM_BITS      = DUR_BITS + 2;    // sum of three averages
   localparam int PCT_BITS      = 7;
   localparam int PCT_SCALE     = 100;
   localparam int NUM_BITS      = DUR_BITS + PCT_BITS;   // avg * 100
   localparam int DIV_BITS      = SUM_BITS + PCT_BITS - 1; // sum << 6
   localparam int AVG_OUT_BITS  = 16;
   localparam int CHUNK_BITS    = 32;
   localparam int LEVEL_BITS    = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam int REQ_DATA_BITS = 112;
   localparam int RSP_DATA_BITS = 96;

   typedef struct packed {
      logic [DUR_BITS-1:0]   avg_net;
      logic [DUR_BITS-1:0]   avg_cpu;
      logic [DUR_BITS-1:0]   avg_sd;
      logic [CHUNK_BITS-1:0] chunk;
      logic [LEVEL_BITS-1:0] level;
   } entry_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic full;
   } wr_ctl_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } rd_ctl_type;

   function automatic logic [AVG_OUT_BITS-1:0] sat16(input logic [DUR_BITS-1:0] v);
      logic [DUR_BITS-1:0] hi;
      hi = v >> AVG_OUT_BITS;
      if (hi != '0) begin
         sat16 = '1;
      end else begin
         sat16 = AVG_OUT_BITS'(v);
      end
   endfunction

   // (3*avg + sample) >> 2
   function automatic logic [DUR_BITS-1:0] ema_step(input logic [DUR_BITS-1:0] avg,
                                                   input logic [DUR_BITS-1:0] sample);
      logic [SUM_BITS-1:0] acc;
      acc = (SUM_BITS'(avg) << 1) + SUM_BITS'(avg) + SUM_BITS'(sample);
      ema_step = DUR_BITS'(acc >> 2);
   endfunction

endpackage

### rtl/tclm_front.sv
// ----------------------------------------------------------------------------
// Load monitor front end
// Accepts items, updates the three running averages and queues a snapshot.
// ----------------------------------------------------------------------------
module tclm_front
   import tclm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [IN_DUR_BITS-1:0] net_us,
   input  logic [IN_DUR_BITS-1:0] cpu_us,
   input  logic [IN_DUR_BITS-1:0] sd_us,
   input  logic [CHUNK_BITS-1:0]  chunk_number,
   input  logic [LEVEL_BITS-1:0]  signal_level,
   input  logic                   restart,
   input  logic                   q_full,
   output wr_ctl_type             q_wr,
   output entry_type              q_data
);

   logic [DUR_BITS-1:0] avg_net_ff, avg_cpu_ff, avg_sd_ff;
   logic [DUR_BITS-1:0] avg_net_in, avg_cpu_in, avg_sd_in;
   logic [DUR_BITS-1:0] net_m, cpu_m, sd_m;
   logic                seeded_ff, seeded_in;
   logic                accept;
   logic                seed;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign seed     = !seeded_ff || restart;

   assign net_m = DUR_BITS'(net_us);
   assign cpu_m = DUR_BITS'(cpu_us);
   assign sd_m  = DUR_BITS'(sd_us);

   always_comb begin
      avg_net_in = avg_net_ff;
      avg_cpu_in = avg_cpu_ff;
      avg_sd_in  = avg_sd_ff;
      seeded_in  = seeded_ff;
      if (accept) begin
         seeded_in = 1'b1;
         if (seed) begin
            avg_net_in = net_m;
            avg_cpu_in = cpu_m;
            avg_sd_in  = sd_m;
         end else begin
            avg_net_in = ema_step(avg_net_ff, net_m);
            avg_cpu_in = ema_step(avg_cpu_ff, cpu_m);
            avg_sd_in  = ema_step(avg_sd_ff, sd_m);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_net_ff <= '0;
         avg_cpu_ff <= '0;
         avg_sd_ff  <= '0;
         seeded_ff  <= 1'b0;
      end else begin
         avg_net_ff <= avg_net_in;
         avg_cpu_ff <= avg_cpu_in;
         avg_sd_ff  <= avg_sd_in;
         seeded_ff  <= seeded_in;
      end
   end

   assign q_wr.push    = accept;
   assign q_wr.full    = q_full;
   assign q_data.avg_net = avg_net_in;
   assign q_data.avg_cpu = avg_cpu_in;
   assign q_data.avg_sd  = avg_sd_in;
   assign q_data.chunk   = chunk_number;
   assign q_data.level   = signal_level;

endmodule

### rtl/tclm_fifo.sv
// ----------------------------------------------------------------------------
// Load monitor queue
// Short register queue between the averaging front and the divider back.
// ----------------------------------------------------------------------------
module tclm_fifo
   import tclm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  wr_ctl_type wr,
   input  entry_type  wr_data,
   output logic       full,
   input  logic       pop,
   output rd_ctl_type rd,
   output entry_type  rd_data
);

`include "three_channel_ema_load_monitor_macros.svh"

   entry_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QUEUE_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign do_push = wr.push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign rd.pop   = do_pop;
   assign rd.empty = (count_ff == '0);
   assign rd_data  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   `TCLM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count past depth")
   `TCLM_ASSERT_IMPL(a_no_push_full, clock, reset, wr.push, !wr.full, "push into full queue")

endmodule

### rtl/tclm_back.sv
// ----------------------------------------------------------------------------
// Load monitor back end
// Pops a snapshot, forms the load share with a bit-serial divider, reports.
// ----------------------------------------------------------------------------
module tclm_back
   import tclm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  rd_ctl_type              q_rd,
   input  entry_type               q_data,
   output logic                    q_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [CHUNK_BITS-1:0]   report_chunk,
   output logic [AVG_OUT_BITS-1:0] net_average,
   output logic [AVG_OUT_BITS-1:0] cpu_average,
   output logic [AVG_OUT_BITS-1:0] sd_average,
   output logic [LEVEL_BITS-1:0]   report_level,
   output logic [PCT_BITS-1:0]     load_percent
);

`include "three_channel_ema_load_monitor_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;
   localparam logic [2:0] LAST_BIT = 3'(PCT_BITS - 1);

   logic [1:0]            state_ff, state_in;
   entry_type             work_ff;
   logic [NUM_BITS-1:0]   rem_ff;
   logic [DIV_BITS-1:0]   dsh_ff;
   logic [PCT_BITS-1:0]   quo_ff;
   logic [2:0]            bit_ff;
   logic                  zero_ff;
   logic [SUM_BITS-1:0]   sum;
   logic [DIV_BITS:0]     rem_ext;
   logic [DIV_BITS:0]     trial;
   logic                  fits;
   logic                  out_load;
   logic [PCT_BITS-1:0]   pct;

   logic                    out_valid_ff;
   logic [CHUNK_BITS-1:0]   chunk_ff;
   logic [AVG_OUT_BITS-1:0] net_ff, cpu_ff, sd_ff;
   logic [LEVEL_BITS-1:0]   level_ff;
   logic [PCT_BITS-1:0]     pct_ff;

   assign q_pop = (state_ff == S_IDLE) && !q_rd.empty;
   assign sum   = SUM_BITS'(work_ff.avg_net) + SUM_BITS'(work_ff.avg_cpu)
                + SUM_BITS'(work_ff.avg_sd);

   // restoring divide: quotient never exceeds 100, so seven steps suffice
   assign rem_ext = (DIV_BITS + 1)'(rem_ff);
   assign trial   = (DIV_BITS + 1)'(dsh_ff);
   assign fits    = (rem_ext >= trial);

   assign out_load = (state_ff == S_FIN) && (!out_valid_ff || out_ready);
   assign pct      = zero_ff ? '0 : quo_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_rd.empty) begin
               state_in = S_CALC;
            end
         end
         S_CALC: state_in = S_DIV;
         S_DIV: begin
            if (bit_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_data;
      end
      if (state_ff == S_CALC) begin
         rem_ff  <= NUM_BITS'(work_ff.avg_cpu) * NUM_BITS'(PCT_SCALE);
         dsh_ff  <= DIV_BITS'(sum) << (PCT_BITS - 1);
         zero_ff <= (sum == '0);
         quo_ff  <= '0;
         bit_ff  <= LAST_BIT;
      end
      if (state_ff == S_DIV) begin
         if (fits) begin
            rem_ff <= NUM_BITS'(rem_ext - trial);
         end
         quo_ff <= {quo_ff[PCT_BITS-2:0], fits};
         dsh_ff <= dsh_ff >> 1;
         bit_ff <= bit_ff - 1'b1;
      end
      if (out_load) begin
         chunk_ff <= work_ff.chunk;
         net_ff   <= sat16(work_ff.avg_net);
         cpu_ff   <= sat16(work_ff.avg_cpu);
         sd_ff    <= sat16(work_ff.avg_sd);
         level_ff <= work_ff.level;
         pct_ff   <= pct;
      end
   end

   assign out_valid    = out_valid_ff;
   assign report_chunk = chunk_ff;
   assign net_average  = net_ff;
   assign cpu_average  = cpu_ff;
   assign sd_average   = sd_ff;
   assign report_level = level_ff;
   assign load_percent = pct_ff;

   `TCLM_ASSERT_IMPL(a_pct_range, clock, reset, out_load, pct <= PCT_BITS'(PCT_SCALE), "load share above 100")
   `TCLM_ASSERT_IMPL(a_pop_idle, clock, reset, q_rd.pop, state_ff == S_IDLE, "queue pop while divider busy")
   `TCLM_ASSERT_IMPL(a_div_count, clock, reset, state_ff == S_DIV, bit_ff <= LAST_BIT, "divider step count out of range")

endmodule

### rtl/three_channel_ema_load_monitor.sv
// Items: the back end pops, sets up, runs the 7-step serial divider and reports one
//   item at a time; a 2-entry queue lets the front take items while the divider works.
// Reset: synchronous, active high; clears averages, seed flag, queue and valids.
// ----------------------------------------------------------------------------
// Three channel EMA load monitor
// Tracks network, processing and storage averages and reports the load share.
// ----------------------------------------------------------------------------
module three_channel_ema_load_monitor
   import tclm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // net_us[23:0], cpu_us[47:24], sd_us[71:48], chunk_number[103:72],
   // signal_level[105:104], zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // restart[0]
   input  logic [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // report_chunk[31:0], net_average[47:32], cpu_average[63:48],
   // sd_average[79:64], report_level[81:80], load_percent[88:82], zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   wr_ctl_type              q_wr;
   rd_ctl_type              q_rd;
   entry_type               q_wdata;
   entry_type               q_rdata;
   logic                    q_full;
   logic                    q_pop;
   logic [CHUNK_BITS-1:0]   report_chunk;
   logic [AVG_OUT_BITS-1:0] net_average, cpu_average, sd_average;
   logic [LEVEL_BITS-1:0]   report_level;
   logic [PCT_BITS-1:0]     load_percent;

   tclm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .net_us       (req_tdata[23:0]),
      .cpu_us       (req_tdata[47:24]),
      .sd_us        (req_tdata[71:48]),
      .chunk_number (req_tdata[103:72]),
      .signal_level (req_tdata[105:104]),
      .restart      (req_tuser[0]),
      .q_full       (q_full),
      .q_wr         (q_wr),
      .q_data       (q_wdata)
   );

   tclm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .rd      (q_rd),
      .rd_data (q_rdata)
   );

   tclm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_rd         (q_rd),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .report_chunk (report_chunk),
      .net_average  (net_average),
      .cpu_average  (cpu_average),
      .sd_average   (sd_average),
      .report_level (report_level),
      .load_percent (load_percent)
   );

   assign rsp_tdata = {7'd0, load_percent, report_level, sd_average, cpu_average,
                       net_average, report_chunk};

endmodule

### sim/load_report_checker.sv
// ----------------------------------------------------------------------------
// Load monitor report checker
// Watches the chunk and report streams. Keeps its own running averages and
// seed flag, predicts one report per accepted chunk, and compares each report
// with the oldest prediction field by field. The mismatch count and the
// number of reports still outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module load_report_checker
   import tclm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // net_us, cpu_us, sd_us, chunk_number, signal_level, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // restart
   input  logic [0:0]               req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // report_chunk, net_average, cpu_average, sd_average, report_level,
   // load_percent, zero fill
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output int unsigned              fail_count,
   output int unsigned              reports_open,
   output int unsigned              reports_seen
);

   localparam int NET_LSB   = 0;
   localparam int CPU_LSB   = IN_DUR_BITS;
   localparam int SD_LSB    = 2 * IN_DUR_BITS;
   localparam int CHUNK_LSB = 3 * IN_DUR_BITS;
   localparam int LEVEL_LSB = CHUNK_LSB + CHUNK_BITS;

   localparam int R_NET_LSB   = CHUNK_BITS;
   localparam int R_CPU_LSB   = R_NET_LSB + AVG_OUT_BITS;
   localparam int R_SD_LSB    = R_CPU_LSB + AVG_OUT_BITS;
   localparam int R_LEVEL_LSB = R_SD_LSB + AVG_OUT_BITS;
   localparam int R_PCT_LSB   = R_LEVEL_LSB + LEVEL_BITS;

   typedef struct packed {
      logic [CHUNK_BITS-1:0]   chunk;
      logic [AVG_OUT_BITS-1:0] net_avg;
      logic [AVG_OUT_BITS-1:0] cpu_avg;
      logic [AVG_OUT_BITS-1:0] sd_avg;
      logic [LEVEL_BITS-1:0]   level;
      logic [PCT_BITS-1:0]     percent;
   } load_report_type;

   logic [DUR_BITS-1:0] net_mean;
   logic [DUR_BITS-1:0] cpu_mean;
   logic [DUR_BITS-1:0] sd_mean;
   logic                history_valid;
   load_report_type     expected_reports[$];

   // alpha = 1/4: three parts old mean, one part new sample
   function automatic logic [DUR_BITS-1:0] smooth(input logic [DUR_BITS-1:0] mean,
                                                  input logic [DUR_BITS-1:0] sample);
      longint unsigned acc;
      acc = mean;
      acc = acc * 3 + sample;
      return DUR_BITS'(acc >> 2);
   endfunction

   function automatic logic [AVG_OUT_BITS-1:0] clamp_avg(input logic [DUR_BITS-1:0] v);
      longint unsigned top_val;
      top_val = (longint'(1) << AVG_OUT_BITS) - 1;
      if (v > top_val) begin
         return '1;
      end
      return AVG_OUT_BITS'(v);
   endfunction

   // advances the running means and builds the report for one chunk
   function automatic load_report_type next_report(input logic [REQ_DATA_BITS-1:0] data,
                                                   input logic restart);
      logic [DUR_BITS-1:0] net_s;
      logic [DUR_BITS-1:0] cpu_s;
      logic [DUR_BITS-1:0] sd_s;
      longint unsigned     total;
      longint unsigned     share;
      load_report_type     rep;
      net_s = DUR_BITS'(data[NET_LSB +: IN_DUR_BITS]);
      cpu_s = DUR_BITS'(data[CPU_LSB +: IN_DUR_BITS]);
      sd_s  = DUR_BITS'(data[SD_LSB +: IN_DUR_BITS]);
      if (!history_valid || restart) begin
         net_mean = net_s;
         cpu_mean = cpu_s;
         sd_mean  = sd_s;
      end else begin
         net_mean = smooth(net_mean, net_s);
         cpu_mean = smooth(cpu_mean, cpu_s);
         sd_mean  = smooth(sd_mean, sd_s);
      end
      history_valid = 1'b1;
      // share uses full-width means, not the clamped copies
      total = longint'(net_mean) + longint'(cpu_mean) + longint'(sd_mean);
      share = 0;
      if (total != 0) begin
         share = (longint'(cpu_mean) * PCT_SCALE) / total;
      end
      rep.chunk   = data[CHUNK_LSB +: CHUNK_BITS];
      rep.net_avg = clamp_avg(net_mean);
      rep.cpu_avg = clamp_avg(cpu_mean);
      rep.sd_avg  = clamp_avg(sd_mean);
      rep.level   = data[LEVEL_LSB +: LEVEL_BITS];
      rep.percent = PCT_BITS'(share);
      return rep;
   endfunction

   task automatic compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      load_report_type want;
      load_report_type got;
      if (reset) begin
         net_mean      = '0;
         cpu_mean      = '0;
         sd_mean       = '0;
         history_valid = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.chunk   = rsp_tdata[0 +: CHUNK_BITS];
            got.net_avg = rsp_tdata[R_NET_LSB +: AVG_OUT_BITS];
            got.cpu_avg = rsp_tdata[R_CPU_LSB +: AVG_OUT_BITS];
            got.sd_avg  = rsp_tdata[R_SD_LSB +: AVG_OUT_BITS];
            got.level   = rsp_tdata[R_LEVEL_LSB +: LEVEL_BITS];
            got.percent = rsp_tdata[R_PCT_LSB +: PCT_BITS];
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $error("report for chunk %0d with no chunk outstanding", got.chunk);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("report_chunk", want.chunk, got.chunk);
               compare_field("net_average", want.net_avg, got.net_avg);
               compare_field("cpu_average", want.cpu_avg, got.cpu_avg);
               compare_field("sd_average", want.sd_avg, got.sd_avg);
               compare_field("report_level", want.level, got.level);
               compare_field("load_percent", want.percent, got.percent);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(next_report(req_tdata, req_tuser[0]));
         end
      end
      reports_open = expected_reports.size();
   end

endmodule

### sim/three_channel_ema_load_monitor_tb.sv
// ----------------------------------------------------------------------------
// Load monitor testbench
// Directed chunks for seeding, restart, zero totals, saturation and bit
// patterns, then random runs of chunks under several sender idle and
// receiver stall mixes, including one long output hold-off.
// ----------------------------------------------------------------------------
module three_channel_ema_load_monitor_tb;
   import tclm_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 115;
   localparam int PRESS_ITEMS  = 40;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [0:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned reports_open;
   int unsigned reports_seen;

   int unsigned sender_idle;
   int unsigned receiver_stall;
   logic        pressure_phase;
   logic        pressure_served;
   int unsigned chunks_sent;
   int unsigned restarts_sent;

   three_channel_ema_load_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   load_report_checker report_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .reports_open (reports_open),
      .reports_seen (reports_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle budget
   initial begin
      int cycle;
      for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) begin
         @(posedge clock);
      end
      $display("three_channel_ema_load_monitor_tb NOT OK");
      $finish;
   end

   // report side: random stalls, plus one long hold-off in the pressure phase
   initial begin
      rsp_tready = 1'b0;
      pressure_served = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_phase && !pressure_served) begin
            pressure_served = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall);
      end
   end

   task automatic send_chunk(input logic [IN_DUR_BITS-1:0] net,
                             input logic [IN_DUR_BITS-1:0] cpu,
                             input logic [IN_DUR_BITS-1:0] sd,
                             input logic [CHUNK_BITS-1:0]  chunk,
                             input logic [LEVEL_BITS-1:0]  level,
                             input logic                   restart);
      while ($urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'({level, chunk, sd, cpu, net});
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      chunks_sent++;
      if (restart) begin
         restarts_sent++;
      end
   endtask

   // a mix of zero, all-ones, small, 16-bit, around-the-clamp and full 24-bit times
   function automatic logic [IN_DUR_BITS-1:0] pick_duration();
      case ($urandom_range(9)) inside
         0:       return '0;
         1:       return '1;
         [2:4]:   return IN_DUR_BITS'($urandom_range(65535));
         5:       return IN_DUR_BITS'($urandom_range(200));
         6:       return IN_DUR_BITS'($urandom_range(65535) + 50000);
         default: return IN_DUR_BITS'($urandom);
      endcase
   endfunction

   task automatic send_random(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         send_chunk(pick_duration(), pick_duration(), pick_duration(), $urandom,
                    LEVEL_BITS'($urandom_range(3)), ($urandom_range(15) == 0));
      end
   endtask

   initial begin
      int unsigned p;
      int unsigned idle_mix[4];
      int unsigned stall_mix[4];
      idle_mix  = '{0, 60, 0, 31};
      stall_mix = '{0, 0, 60, 31};
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      sender_idle    = 0;
      receiver_stall = 0;
      pressure_phase = 1'b0;
      chunks_sent    = 0;
      restarts_sent  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first chunk after reset seeds without restart
      send_chunk(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 2'd3, 1'b0);
      send_chunk(24'h0, 24'h0, 24'h0, 32'h0, 2'd0, 1'b0);
      // zero total gives zero share
      send_chunk(24'h0, 24'h0, 24'h0, 32'd1, 2'd1, 1'b1);
      send_chunk(24'h0, 24'h0, 24'h0, 32'd2, 2'd2, 1'b0);
      // processing only: full share
      send_chunk(24'h0, 24'd123456, 24'h0, 32'd3, 2'd3, 1'b1);
      // around the 16-bit clamp
      send_chunk(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 32'd4, 2'd0, 1'b1);
      send_chunk(24'h010000, 24'h010000, 24'h010000, 32'd5, 2'd1, 1'b0);
      send_chunk(24'h010000, 24'h010000, 24'h010000, 32'd6, 2'd2, 1'b1);
      send_chunk(24'd10000, 24'd10000, 24'd10000, 32'd7, 2'd3, 1'b0);
      send_chunk(24'd1, 24'd0, 24'd0, 32'd8, 2'd0, 1'b1);
      send_chunk(24'd0, 24'd1, 24'd2, 32'd9, 2'd1, 1'b0);
      send_chunk(24'hFFFFFF, 24'h0, 24'h0, 32'd10, 2'd2, 1'b1);
      send_chunk(24'h0, 24'hFFFFFF, 24'h0, 32'd11, 2'd3, 1'b0);
      send_chunk(24'h0, 24'hFFFFFF, 24'h0, 32'd12, 2'd0, 1'b0);
      send_chunk(24'h0, 24'h0, 24'hFFFFFF, 32'd13, 2'd1, 1'b0);
      send_chunk(24'd3, 24'd3, 24'd3, 32'd14, 2'd2, 1'b1);
      // truncation of the smoothing shift
      send_chunk(24'd7, 24'd5, 24'd1, 32'd15, 2'd3, 1'b0);
      send_chunk(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 32'hAAAAAAAA, 2'd2, 1'b1);
      send_chunk(24'h555555, 24'hAAAAAA, 24'h555555, 32'h55555555, 2'd1, 1'b0);

      for (p = 0; p < 4; p++) begin
         sender_idle    = idle_mix[p];
         receiver_stall = stall_mix[p];
         send_random(PHASE_ITEMS);
      end

      // sender keeps offering while the report side is held off
      sender_idle    = 0;
      receiver_stall = 0;
      pressure_phase = 1'b1;
      send_random(PRESS_ITEMS);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (reports_open == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d chunks (%0d with restart), checked %0d reports;", chunks_sent,
               restarts_sent, reports_seen);
      $display("mixes: free flow, idle sender, stalled receiver, both, %0d-cycle hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("three_channel_ema_load_monitor_tb OK");
      end else begin
         $display("three_channel_ema_load_monitor_tb NOT OK");
      end
      $finish;
   end

endmodule

### three_channel_ema_load_monitor.f
+incdir+rtl
rtl/tclm_pkg.sv
rtl/tclm_front.sv
rtl/tclm_fifo.sv
rtl/tclm_back.sv
rtl/three_channel_ema_load_monitor.sv
sim/load_report_checker.sv
sim/three_channel_ema_load_monitor_tb.sv
